FILE: rtl/ycc_pkg.sv
// ============================================================================
// ycc_pkg
// Shared types and constants for the 4:2:0 YCbCr to RGB block converter.
// ============================================================================
package ycc_pkg;

    localparam int SAMPLE_W = 8;
    localparam int GAIN_W   = 16;
    localparam int FRAC_W   = 4;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LANES    = 4;
    localparam int POS_W    = 2;

    // Offset-removed samples: luma -16..239, chroma -128..127.
    localparam int OFS_W  = 9;
    localparam int PROD_W = GAIN_W + 1 + OFS_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic [OFS_W-1:0] LUMA_OFFSET   = 9'd16;
    localparam logic [OFS_W-1:0] CHROMA_BIAS   = 9'd128;
    localparam logic [SAMPLE_W-1:0] PIXEL_MAX  = 8'd255;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_CR_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_CR_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_CB_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_CB_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION_BITS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UPSAMPLE_MODE = 3'd6;

    typedef enum logic [MODE_W-1:0] {
        UP_ZERO      = 2'd0,
        UP_REPLICATE = 2'd1,
        UP_AVERAGE   = 2'd2
    } ycc_up_mode_t;

    typedef struct packed {
        logic [GAIN_W-1:0] luma_gain;
        logic [GAIN_W-1:0] red_cr_gain;
        logic [GAIN_W-1:0] green_cr_gain;
        logic [GAIN_W-1:0] green_cb_gain;
        logic [GAIN_W-1:0] blue_cb_gain;
        logic [FRAC_W-1:0] fraction_bits;
        logic [MODE_W-1:0] upsample_mode;
    } ycc_cfg_t;

    localparam ycc_cfg_t CFG_RESET = '{
        luma_gain:     16'd298,
        red_cr_gain:   16'd409,
        green_cr_gain: 16'd208,
        green_cb_gain: 16'd100,
        blue_cb_gain:  16'd517,
        fraction_bits: 4'd8,
        upsample_mode: 2'd2
    };

    typedef struct packed {
        logic [SAMPLE_W-1:0] luma_00;
        logic [SAMPLE_W-1:0] luma_01;
        logic [SAMPLE_W-1:0] luma_10;
        logic [SAMPLE_W-1:0] luma_11;
        logic [SAMPLE_W-1:0] cb_00;
        logic [SAMPLE_W-1:0] cb_01;
        logic [SAMPLE_W-1:0] cb_10;
        logic [SAMPLE_W-1:0] cb_11;
        logic [SAMPLE_W-1:0] cr_00;
        logic [SAMPLE_W-1:0] cr_01;
        logic [SAMPLE_W-1:0] cr_10;
        logic [SAMPLE_W-1:0] cr_11;
    } ycc_in_word_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
    } ycc_rgb_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic [POS_W-1:0]    pixel_position;
        logic                last_of_block;
    } ycc_out_word_t;

    // Load strobes for the four lane pipeline stages.
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
        logic load4;
    } ycc_stage_ctrl_t;

endpackage

FILE: rtl/ycc_in_if.sv
// ============================================================================
// ycc_in_if
// Valid/ready channel carrying one 2x2 luma block with its chroma samples.
// ============================================================================
interface ycc_in_if;
    import ycc_pkg::*;

    logic         valid;
    logic         ready;
    ycc_in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ycc_out_if.sv
// ============================================================================
// ycc_out_if
// Valid/ready channel carrying one converted RGB pixel.
// ============================================================================
interface ycc_out_if;
    import ycc_pkg::*;

    logic          valid;
    logic          ready;
    ycc_out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ycc_chroma_fill.sv
// ============================================================================
// ycc_chroma_fill
// Upsamples one chroma plane from its 2x2 neighborhood to four pixels.
// ============================================================================
module ycc_chroma_fill (
    input  logic [ycc_pkg::MODE_W-1:0]   mode,
    input  logic [ycc_pkg::SAMPLE_W-1:0] c00,
    input  logic [ycc_pkg::SAMPLE_W-1:0] c01,
    input  logic [ycc_pkg::SAMPLE_W-1:0] c10,
    input  logic [ycc_pkg::SAMPLE_W-1:0] c11,
    output logic [ycc_pkg::SAMPLE_W-1:0] up [ycc_pkg::LANES]
);
    import ycc_pkg::*;

    logic [SAMPLE_W:0]   sum_top;
    logic [SAMPLE_W:0]   sum_left;
    logic [SAMPLE_W+1:0] sum_mid;

    assign sum_top  = {1'b0, c00} + {1'b0, c01} + 9'd1;
    assign sum_left = {1'b0, c00} + {1'b0, c10} + 9'd1;
    assign sum_mid  = {2'b00, c00} + {2'b00, c01} + {2'b00, c10} + {2'b00, c11} + 10'd2;

    always_comb
    begin
        up[0] = c00;
        unique case (mode)
            UP_REPLICATE:
            begin
                up[1] = c00;
                up[2] = c00;
                up[3] = c00;
            end
            UP_AVERAGE:
            begin
                up[1] = sum_top[SAMPLE_W:1];
                up[2] = sum_left[SAMPLE_W:1];
                up[3] = sum_mid[SAMPLE_W+1:2];
            end
            default:
            begin
                // Zero fill; the unused mode code behaves the same.
                up[1] = '0;
                up[2] = '0;
                up[3] = '0;
            end
        endcase
    end

endmodule

FILE: rtl/ycc_lane.sv
// ============================================================================
// ycc_lane
// Four-stage pipeline converting one pixel: offsets, products, sums with
// rounding, then arithmetic shift and clamp.
// ============================================================================
module ycc_lane (
    input  logic                         clk,
    input  ycc_pkg::ycc_cfg_t            cfg,
    input  ycc_pkg::ycc_stage_ctrl_t     ctrl,
    input  logic [ycc_pkg::SAMPLE_W-1:0] luma,
    input  logic [ycc_pkg::SAMPLE_W-1:0] cb,
    input  logic [ycc_pkg::SAMPLE_W-1:0] cr,
    output ycc_pkg::ycc_rgb_t            rgb
);
    import ycc_pkg::*;

    logic signed [OFS_W-1:0]  y_reg,  cb_reg,  cr_reg;
    logic signed [PROD_W-1:0] ly_reg, rcr_reg, gcr_reg, gcb_reg, bcb_reg;
    logic signed [SUM_W-1:0]  r_sum_reg, g_sum_reg, b_sum_reg;
    ycc_rgb_t                 rgb_reg;

    logic signed [PROD_W-1:0] ly_next, rcr_next, gcr_next, gcb_next, bcb_next;
    logic signed [SUM_W-1:0]  rnd;
    logic signed [SUM_W-1:0]  r_sum_next, g_sum_next, b_sum_next;
    ycc_rgb_t                 rgb_next;

    function automatic logic [SAMPLE_W-1:0] shift_clamp(
        input logic signed [SUM_W-1:0] acc,
        input logic [FRAC_W-1:0]       k
    );
        logic signed [SUM_W-1:0] v;
        v = acc >>> k;
        if (v > $signed({{(SUM_W-SAMPLE_W){1'b0}}, PIXEL_MAX}))
            return PIXEL_MAX;
        else if (v < 0)
            return '0;
        else
            return v[SAMPLE_W-1:0];
    endfunction

    assign ly_next  = $signed({1'b0, cfg.luma_gain})     * y_reg;
    assign rcr_next = $signed({1'b0, cfg.red_cr_gain})   * cr_reg;
    assign gcr_next = $signed({1'b0, cfg.green_cr_gain}) * cr_reg;
    assign gcb_next = $signed({1'b0, cfg.green_cb_gain}) * cb_reg;
    assign bcb_next = $signed({1'b0, cfg.blue_cb_gain})  * cb_reg;

    always_comb
    begin
        if (cfg.fraction_bits == '0)
            rnd = '0;
        else
            rnd = SUM_W'(1) << (cfg.fraction_bits - FRAC_W'(1));
        r_sum_next = SUM_W'(ly_reg) + SUM_W'(rcr_reg) + rnd;
        g_sum_next = SUM_W'(ly_reg) - SUM_W'(gcr_reg) - SUM_W'(gcb_reg) + rnd;
        b_sum_next = SUM_W'(ly_reg) + SUM_W'(bcb_reg) + rnd;
        rgb_next.red   = shift_clamp(r_sum_reg, cfg.fraction_bits);
        rgb_next.green = shift_clamp(g_sum_reg, cfg.fraction_bits);
        rgb_next.blue  = shift_clamp(b_sum_reg, cfg.fraction_bits);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load1)
        begin
            y_reg  <= $signed({1'b0, luma}) - $signed(LUMA_OFFSET);
            cb_reg <= $signed({1'b0, cb}) - $signed(CHROMA_BIAS);
            cr_reg <= $signed({1'b0, cr}) - $signed(CHROMA_BIAS);
        end
        if (ctrl.load2)
        begin
            ly_reg  <= ly_next;
            rcr_reg <= rcr_next;
            gcr_reg <= gcr_next;
            gcb_reg <= gcb_next;
            bcb_reg <= bcb_next;
        end
        if (ctrl.load3)
        begin
            r_sum_reg <= r_sum_next;
            g_sum_reg <= g_sum_next;
            b_sum_reg <= b_sum_next;
        end
        if (ctrl.load4)
            rgb_reg <= rgb_next;
    end

    assign rgb = rgb_reg;

endmodule

FILE: rtl/ycc_merge.sv
// ============================================================================
// ycc_merge
// Collects the four lane results of a block and sends them out one pixel
// per word in raster order.
// ============================================================================
module ycc_merge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              grp_valid,
    output logic              grp_ready,
    input  ycc_pkg::ycc_rgb_t grp_rgb [ycc_pkg::LANES],
    ycc_out_if.source         pix_out
);
    import ycc_pkg::*;

    ycc_rgb_t         buf_reg [LANES];
    logic             full_reg, full_next;
    logic [POS_W-1:0] idx_reg, idx_next;
    logic             take;
    logic             load;

    assign take      = full_reg && pix_out.ready;
    assign grp_ready = !full_reg || (take && (idx_reg == POS_W'(LANES - 1)));
    assign load      = grp_valid && grp_ready;

    always_comb
    begin
        full_next = full_reg;
        idx_next  = idx_reg;
        if (take)
        begin
            idx_next = idx_reg + POS_W'(1);
            if (idx_reg == POS_W'(LANES - 1))
                full_next = 1'b0;
        end
        if (load)
        begin
            full_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            full_reg <= full_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= grp_rgb;
    end

    assign pix_out.valid               = full_reg;
    assign pix_out.data.red            = buf_reg[idx_reg].red;
    assign pix_out.data.green          = buf_reg[idx_reg].green;
    assign pix_out.data.blue           = buf_reg[idx_reg].blue;
    assign pix_out.data.pixel_position = idx_reg;
    assign pix_out.data.last_of_block  = (idx_reg == POS_W'(LANES - 1));

endmodule

FILE: rtl/ycbcr420_to_rgb_block.sv
// ============================================================================
// ycbcr420_to_rgb_block
// 4:2:0 YCbCr to RGB block converter with chroma upsampling.
// ============================================================================
// The input channel takes one word per 2x2 luma block together with the Cb
// and Cr samples of this block and its right, lower and lower-right
// neighbors. The output channel returns four RGB pixel words per block in
// raster order, with the pixel position and a flag on the fourth pixel.
// Four lanes convert the four pixels of a block side by side in a
// four-stage pipeline; a merge buffer then sends them one per cycle while
// the receiver is ready. The first pixel of a block is valid once the word
// has passed the lane stages into the merge buffer; the other three follow.
// The single pixel-wide output channel sets the block rate. A new block is
// accepted while the previous one is still being sent. When the receiver
// stalls, the merge buffer holds its pixel and the lane pipeline fills up;
// input ready falls only once all stages hold a block. Reset empties the
// pipeline and loads the default BT.601 gains, eight fraction bits and
// averaging mode. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user must write it only while the block is idle (not enforced).
// ============================================================================
module ycbcr420_to_rgb_block (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ycc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ycc_pkg::CFG_DATA_W-1:0] cfg_data,
    ycc_in_if.sink                         pix_in,
    ycc_out_if.source                      pix_out
);
    import ycc_pkg::*;

    ycc_cfg_t        cfg_reg, cfg_next;
    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    logic            rdy1, rdy2, rdy3, rdy4;
    logic            grp_ready;
    ycc_stage_ctrl_t ctrl;

    logic [SAMPLE_W-1:0] cb_up   [LANES];
    logic [SAMPLE_W-1:0] cr_up   [LANES];
    logic [SAMPLE_W-1:0] luma_in [LANES];
    ycc_rgb_t            lane_rgb [LANES];

    // Configuration registers.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LUMA_GAIN:     cfg_next.luma_gain     = cfg_data;
                CFG_RED_CR_GAIN:   cfg_next.red_cr_gain   = cfg_data;
                CFG_GREEN_CR_GAIN: cfg_next.green_cr_gain = cfg_data;
                CFG_GREEN_CB_GAIN: cfg_next.green_cb_gain = cfg_data;
                CFG_BLUE_CB_GAIN:  cfg_next.blue_cb_gain  = cfg_data;
                CFG_FRACTION_BITS: cfg_next.fraction_bits = cfg_data[FRAC_W-1:0];
                CFG_UPSAMPLE_MODE: cfg_next.upsample_mode = cfg_data[MODE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    // Stage handshake: a stage loads whenever it is empty or drains.
    assign rdy4 = !v4_reg || grp_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign ctrl.load1 = rdy1;
    assign ctrl.load2 = rdy2;
    assign ctrl.load3 = rdy3;
    assign ctrl.load4 = rdy4;

    assign pix_in.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= pix_in.valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    ycc_chroma_fill u_cb_fill (
        .mode (cfg_reg.upsample_mode),
        .c00  (pix_in.data.cb_00),
        .c01  (pix_in.data.cb_01),
        .c10  (pix_in.data.cb_10),
        .c11  (pix_in.data.cb_11),
        .up   (cb_up)
    );

    ycc_chroma_fill u_cr_fill (
        .mode (cfg_reg.upsample_mode),
        .c00  (pix_in.data.cr_00),
        .c01  (pix_in.data.cr_01),
        .c10  (pix_in.data.cr_10),
        .c11  (pix_in.data.cr_11),
        .up   (cr_up)
    );

    assign luma_in[0] = pix_in.data.luma_00;
    assign luma_in[1] = pix_in.data.luma_01;
    assign luma_in[2] = pix_in.data.luma_10;
    assign luma_in[3] = pix_in.data.luma_11;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        ycc_lane u_lane (
            .clk  (clk),
            .cfg  (cfg_reg),
            .ctrl (ctrl),
            .luma (luma_in[i]),
            .cb   (cb_up[i]),
            .cr   (cr_up[i]),
            .rgb  (lane_rgb[i])
        );
    end

    ycc_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (v4_reg),
        .grp_ready (grp_ready),
        .grp_rgb   (lane_rgb),
        .pix_out   (pix_out)
    );

endmodule

FILE: bench/ycbcr420_to_rgb_block_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// ycbcr420_to_rgb_block_tb
// Self-checking bench for the 4:2:0 YCbCr to RGB block converter. A short
// table of directed blocks covers the sample extremes, every upsampling mode
// and the out-of-range fraction settings. It is followed by random blocks
// under several register settings. Each block word is expanded by a local
// fixed-point converter into four expected pixel words, or into the listed
// color where a directed row gives one. These are compared field by field
// with the pixels that leave the block; both channels stall at random but in one phase.
// ============================================================================
module ycbcr420_to_rgb_block_tb;
    import ycc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_COUNT    = 8;
    localparam int BLOCKS_PER_PHASE = 13;

    // Mode code that the package does not name; the block treats it as zero fill.
    localparam logic [MODE_W-1:0] UP_UNDEFINED = 2'd3;

    typedef enum logic [1:0] {
        GAINS_DEFAULT,
        GAINS_ZERO,
        GAINS_MAX
    } gain_set_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [FRAC_W-1:0] frac;
        gain_set_t         gains;
        ycc_in_word_t      word;
        logic              known;
        ycc_rgb_t          rgb;
    } block_case_t;

    // Words are luma 00..11, then Cb 00..11, then Cr 00..11. Where known is set,
    // all four pixels of the block carry the listed color.
    localparam int N_DIRECTED = 24;
    localparam block_case_t DIRECTED_CASES [N_DIRECTED] = '{
        '{UP_AVERAGE,   4'd8,  GAINS_DEFAULT, 96'h10101010_80808080_80808080, 1'b1, 24'h000000},
        '{UP_AVERAGE,   4'd8,  GAINS_DEFAULT, 96'hFFFFFFFF_80808080_80808080, 1'b1, 24'hFFFFFF},
        '{UP_AVERAGE,   4'd8,  GAINS_DEFAULT, 96'h00000000_80808080_80808080, 1'b1, 24'h000000},
        '{UP_AVERAGE,   4'd8,  GAINS_DEFAULT, 96'hFFFFFFFF_00000000_00000000, 1'b0, 24'h000000},
        '{UP_AVERAGE,   4'd8,  GAINS_DEFAULT, 96'h00000000_FFFFFFFF_FFFFFFFF, 1'b0, 24'h000000},
        '{UP_AVERAGE,   4'd8,  GAINS_DEFAULT, 96'h00FF00FF_00FFFF00_FF0000FF, 1'b0, 24'h000000},
        '{UP_AVERAGE,   4'd8,  GAINS_DEFAULT, 96'h50607080_00010001_01000100, 1'b0, 24'h000000},
        '{UP_AVERAGE,   4'd8,  GAINS_DEFAULT, 96'hEB10EB10_FF000000_00FFFFFF, 1'b0, 24'h000000},
        '{UP_REPLICATE, 4'd8,  GAINS_DEFAULT, 96'h10101010_80000000_80FFFFFF, 1'b1, 24'h000000},
        '{UP_REPLICATE, 4'd8,  GAINS_DEFAULT, 96'h3C5A7896_2040C0E0_E0C04020, 1'b0, 24'h000000},
        '{UP_ZERO,      4'd8,  GAINS_DEFAULT, 96'h80808080_80808080_80808080, 1'b0, 24'h000000},
        '{UP_ZERO,      4'd8,  GAINS_DEFAULT, 96'h10EB10EB_FF7F0180_00FF8040, 1'b0, 24'h000000},
        '{UP_UNDEFINED, 4'd8,  GAINS_DEFAULT, 96'h80808080_80808080_80808080, 1'b0, 24'h000000},
        '{UP_UNDEFINED, 4'd8,  GAINS_DEFAULT, 96'h10EB10EB_FF7F0180_00FF8040, 1'b0, 24'h000000},
        '{UP_AVERAGE,   4'd0,  GAINS_DEFAULT, 96'h10101010_80808080_80808080, 1'b1, 24'h000000},
        '{UP_AVERAGE,   4'd0,  GAINS_DEFAULT, 96'h11111111_80808080_80808080, 1'b1, 24'hFFFFFF},
        '{UP_AVERAGE,   4'd0,  GAINS_DEFAULT, 96'h2010FF00_7F81807F_80817F80, 1'b0, 24'h000000},
        '{UP_AVERAGE,   4'd15, GAINS_DEFAULT, 96'hFFFFFFFF_80808080_80808080, 1'b0, 24'h000000},
        '{UP_AVERAGE,   4'd15, GAINS_DEFAULT, 96'h00FF80EB_FF00FF00_00FF00FF, 1'b0, 24'h000000},
        '{UP_AVERAGE,   4'd8,  GAINS_ZERO,    96'hFFFFFFFF_00000000_00000000, 1'b1, 24'h000000},
        '{UP_AVERAGE,   4'd14, GAINS_MAX,     96'hFFFFFFFF_FFFFFFFF_FFFFFFFF, 1'b0, 24'h000000},
        '{UP_AVERAGE,   4'd1,  GAINS_MAX,     96'h00000000_00000000_00000000, 1'b0, 24'h000000},
        '{UP_REPLICATE, 4'd14, GAINS_DEFAULT, 96'h9A10EB42_C8000000_37000000, 1'b0, 24'h000000},
        '{UP_AVERAGE,   4'd8,  GAINS_DEFAULT, 96'h7F807F80_80808080_80808080, 1'b0, 24'h000000}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ycc_in_if  pix_in_ch ();
    ycc_out_if pix_out_ch ();

    ycc_cfg_t      active_cfg = CFG_RESET;
    ycc_out_word_t expected_pixels [$];
    int            stall_pct  = 21;
    int            fail_count = 0;
    int            quiet_cycles = 0;

    ycbcr420_to_rgb_block u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in_ch),
        .pix_out   (pix_out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int upsample_chroma(input logic [MODE_W-1:0] mode, input int p,
                                           input int c00, input int c01,
                                           input int c10, input int c11);
        if (p == 0)
            return c00;
        case (mode)
            UP_REPLICATE: return c00;
            UP_AVERAGE:
            begin
                case (p)
                    1:       return (c00 + c01 + 1) >> 1;
                    2:       return (c00 + c10 + 1) >> 1;
                    default: return (c00 + c01 + c10 + c11 + 2) >> 2;
                endcase
            end
            default: return 0;
        endcase
    endfunction

    // Round, floor-shift by the fraction bits, then clamp to a pixel value.
    function automatic logic [SAMPLE_W-1:0] scale_to_pixel(input longint acc,
                                                           input logic [FRAC_W-1:0] k);
        longint v;
        if (k != 0)
            acc += longint'(1) <<< (k - 1);
        v = acc >>> k;
        if (v > longint'(PIXEL_MAX))
            return PIXEL_MAX;
        if (v < 0)
            return '0;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic ycc_out_word_t convert_pixel(input ycc_cfg_t c, input ycc_in_word_t w,
                                                    input int p);
        logic [SAMPLE_W-1:0] luma [LANES];
        longint        y;
        longint        cb;
        longint        cr;
        longint        ly;
        ycc_out_word_t px;
        luma = '{w.luma_00, w.luma_01, w.luma_10, w.luma_11};
        y  = longint'(luma[p]) - longint'(LUMA_OFFSET);
        cb = longint'(upsample_chroma(c.upsample_mode, p, int'(w.cb_00), int'(w.cb_01),
                                      int'(w.cb_10), int'(w.cb_11)))
             - longint'(CHROMA_BIAS);
        cr = longint'(upsample_chroma(c.upsample_mode, p, int'(w.cr_00), int'(w.cr_01),
                                      int'(w.cr_10), int'(w.cr_11)))
             - longint'(CHROMA_BIAS);
        ly = longint'(c.luma_gain) * y;
        px.red   = scale_to_pixel(ly + longint'(c.red_cr_gain) * cr, c.fraction_bits);
        px.green = scale_to_pixel(ly - longint'(c.green_cr_gain) * cr
                                     - longint'(c.green_cb_gain) * cb, c.fraction_bits);
        px.blue  = scale_to_pixel(ly + longint'(c.blue_cb_gain) * cb, c.fraction_bits);
        px.pixel_position = POS_W'(p);
        px.last_of_block  = (p == LANES - 1);
        return px;
    endfunction

    // Half the blocks are plain random; the rest pin luma to its corners or keep chroma
    // close to neutral so that the results do not all clamp.
    function automatic ycc_in_word_t make_block_word();
        logic [SAMPLE_W-1:0] s [12];
        logic [SAMPLE_W-1:0] corner [4];
        int style;
        corner = '{8'd0, 8'd16, 8'd235, 8'd255};
        style  = $urandom_range(0, 3);
        for (int i = 0; i < 12; i++)
        begin
            if (style == 1 && i < LANES)
                s[i] = corner[$urandom_range(0, 3)];
            else if (style == 2 && i >= LANES)
                s[i] = SAMPLE_W'(108 + $urandom_range(0, 40));
            else
                s[i] = SAMPLE_W'($urandom);
        end
        return {s[0], s[1], s[2], s[3], s[4], s[5], s[6], s[7], s[8], s[9], s[10], s[11]};
    endfunction

    // Gains scaled to the fraction bits keep most pixels inside the clamp range.
    function automatic logic [GAIN_W-1:0] rand_gain(input logic [FRAC_W-1:0] frac);
        if ($urandom_range(0, 9) == 0)
            return GAIN_W'($urandom);
        return GAIN_W'($urandom_range(0, (2 << frac) - 1));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        pix_in_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input ycc_cfg_t c);
        drain_pipeline();
        write_reg(CFG_LUMA_GAIN,     c.luma_gain);
        write_reg(CFG_RED_CR_GAIN,   c.red_cr_gain);
        write_reg(CFG_GREEN_CR_GAIN, c.green_cr_gain);
        write_reg(CFG_GREEN_CB_GAIN, c.green_cb_gain);
        write_reg(CFG_BLUE_CB_GAIN,  c.blue_cb_gain);
        write_reg(CFG_FRACTION_BITS, CFG_DATA_W'(c.fraction_bits));
        write_reg(CFG_UPSAMPLE_MODE, CFG_DATA_W'(c.upsample_mode));
        @(negedge clk);
        cfg_we <= 1'b0;
        active_cfg = c;
    endtask

    // Valid stays high from one word to the next unless an idle cycle is drawn.
    task automatic send_block(input ycc_in_word_t w, input logic known, input ycc_rgb_t rgb);
        ycc_out_word_t px;
        @(negedge clk);
        while ($urandom_range(0, 99) < stall_pct)
        begin
            pix_in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pix_in_ch.valid <= 1'b1;
        pix_in_ch.data  <= w;
        @(posedge clk);
        while (!pix_in_ch.ready)
            @(posedge clk);
        for (int p = 0; p < LANES; p++)
        begin
            if (known)
            begin
                px.red            = rgb.red;
                px.green          = rgb.green;
                px.blue           = rgb.blue;
                px.pixel_position = POS_W'(p);
                px.last_of_block  = (p == LANES - 1);
            end
            else
            begin
                px = convert_pixel(active_cfg, w, p);
            end
            expected_pixels.push_back(px);
        end
    endtask

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    initial
    begin : result_sink
        pix_out_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            pix_out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        ycc_out_word_t want;
        if (rst_n && pix_out_ch.valid && pix_out_ch.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                fail_count++;
                $display("%0t ns: pixel word with none expected, actual %h", $time,
                         pix_out_ch.data);
            end
            else
            begin
                want = expected_pixels.pop_front();
                compare_field("red",            want.red,   pix_out_ch.data.red);
                compare_field("green",          want.green, pix_out_ch.data.green);
                compare_field("blue",           want.blue,  pix_out_ch.data.blue);
                compare_field("pixel_position", 8'(want.pixel_position),
                              8'(pix_out_ch.data.pixel_position));
                compare_field("last_of_block",  8'(want.last_of_block),
                              8'(pix_out_ch.data.last_of_block));
            end
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pix_in_ch.valid && pix_in_ch.ready) || (pix_out_ch.valid && pix_out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("ycbcr420_to_rgb_block test failed");
        $finish;
    end

    initial
    begin : stimulus
        ycc_cfg_t          next_cfg;
        block_case_t       bc;
        logic [GAIN_W-1:0] gain_fill;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_LUMA_GAIN;
        cfg_data        <= '0;
        pix_in_ch.valid <= 1'b0;
        pix_in_ch.data  <= '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The first rows run on the reset values of the registers.
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            bc        = DIRECTED_CASES[i];
            next_cfg  = CFG_RESET;
            gain_fill = (bc.gains == GAINS_MAX) ? '1 : '0;
            if (bc.gains != GAINS_DEFAULT)
            begin
                next_cfg.luma_gain     = gain_fill;
                next_cfg.red_cr_gain   = gain_fill;
                next_cfg.green_cr_gain = gain_fill;
                next_cfg.green_cb_gain = gain_fill;
                next_cfg.blue_cb_gain  = gain_fill;
            end
            next_cfg.fraction_bits = bc.frac;
            next_cfg.upsample_mode = bc.mode;
            if (next_cfg != active_cfg)
                apply_config(next_cfg);
            send_block(bc.word, bc.known, bc.rgb);
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            next_cfg = CFG_RESET;
            case (phase)
                0: ;
                1: next_cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                4'd14, UP_AVERAGE};
                2:
                begin
                    next_cfg.fraction_bits = 4'd1;
                    next_cfg.upsample_mode = UP_REPLICATE;
                end
                3:
                begin
                    next_cfg.fraction_bits = FRAC_W'($urandom_range(1, 14));
                    next_cfg.upsample_mode = UP_ZERO;
                end
                4:
                begin
                    next_cfg.fraction_bits = 4'd0;
                    next_cfg.upsample_mode = UP_UNDEFINED;
                end
                5: next_cfg.fraction_bits = 4'd15;
                6: ;
                default:
                begin
                    next_cfg.fraction_bits = FRAC_W'($urandom_range(0, 15));
                    next_cfg.upsample_mode = MODE_W'($urandom_range(0, 3));
                end
            endcase
            if (phase >= 2 && phase != 6)
            begin
                next_cfg.luma_gain     = rand_gain(next_cfg.fraction_bits);
                next_cfg.red_cr_gain   = rand_gain(next_cfg.fraction_bits);
                next_cfg.green_cr_gain = rand_gain(next_cfg.fraction_bits);
                next_cfg.green_cb_gain = rand_gain(next_cfg.fraction_bits);
                next_cfg.blue_cb_gain  = rand_gain(next_cfg.fraction_bits);
            end
            // One phase runs both channels flat out.
            stall_pct = (phase == 6) ? 0 : 21;
            apply_config(next_cfg);
            repeat (BLOCKS_PER_PHASE) send_block(make_block_word(), 1'b0, '0);
        end

        drain_pipeline();
        if (fail_count == 0)
            $display("ycbcr420_to_rgb_block test passed");
        else
            $display("ycbcr420_to_rgb_block test failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/ycc_pkg.sv
rtl/ycc_in_if.sv
rtl/ycc_out_if.sv
rtl/ycc_chroma_fill.sv
rtl/ycc_lane.sv
rtl/ycc_merge.sv
rtl/ycbcr420_to_rgb_block.sv
bench/ycbcr420_to_rgb_block_tb.sv
